// ===== hdl/single_wire_debug_frame_link_defines.svh =====
// assertion macros shared by the single-wire debug frame link rtl
// no dependencies; included inside module bodies
`ifndef SINGLE_WIRE_DEBUG_FRAME_LINK_DEFINES_SVH
`define SINGLE_WIRE_DEBUG_FRAME_LINK_DEFINES_SVH
`ifndef SYNTHESIS
`define SWDFL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swdfl assertion failed");
`define SWDFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swdfl assertion failed");
`else
`define SWDFL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SWDFL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/swdfl_pkg.sv =====
// types and codes of the single-wire debug frame link
// no dependencies
package swdfl_pkg;

    localparam int DATA_BITS = 8;
    localparam int WIDTH_W   = 16;
    localparam int COUNT_W   = 4;

    typedef logic [WIDTH_W-1:0]   width_t;
    typedef logic [DATA_BITS-1:0] byte_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [1:0]           kind_t;
    typedef logic [1:0]           status_t;
    typedef logic [1:0]           reg_index_t;

    // opcodes of an input word
    localparam logic OP_SEND    = 1'b0;
    localparam logic OP_CAPTURE = 1'b1;

    // result kinds
    localparam kind_t KIND_PULSE  = 2'd0;
    localparam kind_t KIND_STATUS = 2'd1;
    localparam kind_t KIND_BYTE   = 2'd2;

    // status codes
    localparam status_t STAT_OK      = 2'd0;
    localparam status_t STAT_NACK    = 2'd1;
    localparam status_t STAT_HDR_ERR = 2'd2;

    // configuration register indexes
    localparam reg_index_t REG_ZERO_WIDTH = 2'd0;
    localparam reg_index_t REG_ONE_WIDTH  = 2'd1;
    localparam reg_index_t REG_THRESHOLD  = 2'd2;

endpackage

// ===== hdl/single_wire_debug_frame_link.sv =====
// single-wire debug frame link: frame encoder, width collector and byte decoder
// depends on swdfl_pkg and single_wire_debug_frame_link_defines.svh
//
//  channel | direction | words                  | handshake
//  --------+-----------+------------------------+--------------------
//  s_      | in        | send or captured width | s_valid / s_ready
//  m_      | out       | pulse, status or byte  | m_valid / m_ready
//  cfg_    | in        | register index, data   | cfg_valid / cfg_ready
//
// a send word gives min(bit_count, 8)+3 pulse words, one per cycle while m_ready does
// not stall: the header goes out in the cycle after acceptance, the value bits leave
// a shift register one a cycle, then parity and terminator
// a captured width gives zero or one word, or three words (byte, ack pulse,
// terminator) when it completes a byte with a good header
// a stalled m_ready holds the output register and the sequencer with it
// reset is synchronous active low; it clears control state and restores the
// reset value 1 of the three width registers, cfg_ready stays high
module single_wire_debug_frame_link (
    input  logic                    aclk,
    input  logic                    aresetn,
    // input words
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_opcode,
    input  swdfl_pkg::byte_t        s_frame_value,
    input  swdfl_pkg::count_t       s_bit_count,
    input  swdfl_pkg::width_t       s_captured_width,
    // result words
    output logic                    m_valid,
    input  logic                    m_ready,
    output swdfl_pkg::kind_t        m_result_kind,
    output swdfl_pkg::width_t       m_drive_width,
    output swdfl_pkg::status_t      m_status_code,
    output swdfl_pkg::byte_t        m_received_byte,
    output logic                    m_last_of_run,
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  swdfl_pkg::reg_index_t   cfg_index,
    input  swdfl_pkg::width_t       cfg_data
);
    import swdfl_pkg::*;
    `include "single_wire_debug_frame_link_defines.svh"

    typedef enum logic [1:0] {
        ST_IDLE,    // takes input words
        ST_SEND,    // value bits, then parity
        ST_ACK,     // ack pulse after a received byte
        ST_TERM     // zero-width terminator, ends the run
    } state_t;

    state_t  state_reg, state_next;

    // configuration
    width_t  zero_width_reg, zero_width_next;
    width_t  one_width_reg, one_width_next;
    width_t  threshold_reg, threshold_next;

    // send shifter, msb leaves first
    byte_t   send_shift_reg, send_shift_next;
    count_t  bits_left_reg, bits_left_next;
    logic    parity_reg, parity_next;

    // link state
    logic    collect_reg, collect_next;
    count_t  width_count_reg, width_count_next;
    count_t  ack_pos_reg, ack_pos_next;
    byte_t   rx_shift_reg, rx_shift_next;
    logic    header_bad_reg, header_bad_next;
    logic    skip_echo_reg, skip_echo_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    kind_t   out_kind_reg, out_kind_next;
    width_t  out_drive_reg, out_drive_next;
    status_t out_status_reg, out_status_next;
    byte_t   out_byte_reg, out_byte_next;
    logic    out_last_reg, out_last_next;

    logic    out_free;
    logic    in_accept;
    count_t  send_count;
    count_t  align_shift;
    logic    is_one;
    logic    is_nack;

    assign out_free  = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign in_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // counts above the data width are sent as full bytes
    assign send_count  = (s_bit_count > COUNT_W'(DATA_BITS)) ? COUNT_W'(DATA_BITS)
                                                             : s_bit_count;
    // left-align the used bits so the first one sits at the msb
    assign align_shift = COUNT_W'(DATA_BITS) - send_count;

    // a width below the threshold reads as one, above it as nack
    assign is_one  = s_captured_width < threshold_reg;
    assign is_nack = s_captured_width > threshold_reg;

    always_comb begin
        state_next       = state_reg;
        zero_width_next  = zero_width_reg;
        one_width_next   = one_width_reg;
        threshold_next   = threshold_reg;
        send_shift_next  = send_shift_reg;
        bits_left_next   = bits_left_reg;
        parity_next      = parity_reg;
        collect_next     = collect_reg;
        width_count_next = width_count_reg;
        ack_pos_next     = ack_pos_reg;
        rx_shift_next    = rx_shift_reg;
        header_bad_next  = header_bad_reg;
        skip_echo_next   = skip_echo_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_kind_next    = out_kind_reg;
        out_drive_next   = out_drive_reg;
        out_status_next  = out_status_reg;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ZERO_WIDTH: zero_width_next = cfg_data;
                REG_ONE_WIDTH:  one_width_next  = cfg_data;
                REG_THRESHOLD:  threshold_next  = cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_opcode == OP_SEND) begin
                        // header zero pulse goes out now
                        out_valid_next   = 1'b1;
                        out_kind_next    = KIND_PULSE;
                        out_drive_next   = zero_width_reg;
                        out_status_next  = STAT_OK;
                        out_byte_next    = '0;
                        out_last_next    = 1'b0;
                        send_shift_next  = s_frame_value << align_shift;
                        bits_left_next   = send_count;
                        parity_next      = 1'b0;
                        state_next       = ST_SEND;
                        // a send drops any partial collection
                        collect_next     = 1'b1;
                        width_count_next = '0;
                        ack_pos_next     = send_count + COUNT_W'(2);
                        rx_shift_next    = '0;
                        header_bad_next  = 1'b0;
                        skip_echo_next   = 1'b0;
                    end else if (collect_reg) begin
                        if (width_count_reg >= ack_pos_reg) begin
                            // target ack slot
                            out_valid_next   = 1'b1;
                            out_kind_next    = KIND_STATUS;
                            out_drive_next   = '0;
                            out_status_next  = is_nack ? STAT_NACK : STAT_OK;
                            out_byte_next    = '0;
                            out_last_next    = 1'b1;
                            collect_next     = 1'b0;
                            width_count_next = '0;
                        end else begin
                            // echo of one of our own pulses
                            width_count_next = width_count_reg + COUNT_W'(1);
                        end
                    end else if (skip_echo_reg) begin
                        skip_echo_next = 1'b0;
                    end else if (width_count_reg == '0) begin
                        header_bad_next  = !is_one;
                        rx_shift_next    = '0;
                        width_count_next = COUNT_W'(1);
                    end else if (width_count_reg <= COUNT_W'(DATA_BITS)) begin
                        rx_shift_next    = {rx_shift_reg[DATA_BITS-2:0], is_one};
                        width_count_next = width_count_reg + COUNT_W'(1);
                    end else begin
                        // parity width closes the byte, its value is ignored
                        width_count_next = '0;
                        out_valid_next   = 1'b1;
                        out_kind_next    = KIND_BYTE;
                        out_drive_next   = '0;
                        if (header_bad_reg) begin
                            out_status_next = STAT_HDR_ERR;
                            out_byte_next   = '0;
                            out_last_next   = 1'b1;
                        end else begin
                            out_status_next = STAT_OK;
                            out_byte_next   = rx_shift_reg;
                            out_last_next   = 1'b0;
                            skip_echo_next  = 1'b1;
                            state_next      = ST_ACK;
                        end
                    end
                end
            end
            ST_SEND: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_PULSE;
                    out_status_next = STAT_OK;
                    out_byte_next   = '0;
                    out_last_next   = 1'b0;
                    if (bits_left_reg != '0) begin
                        out_drive_next  = send_shift_reg[DATA_BITS-1] ? one_width_reg
                                                                      : zero_width_reg;
                        parity_next     = parity_reg ^ send_shift_reg[DATA_BITS-1];
                        send_shift_next = {send_shift_reg[DATA_BITS-2:0], 1'b0};
                        bits_left_next  = bits_left_reg - COUNT_W'(1);
                    end else begin
                        // even parity pulse
                        out_drive_next = parity_reg ? one_width_reg : zero_width_reg;
                        state_next     = ST_TERM;
                    end
                end
            end
            ST_ACK: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_PULSE;
                    out_drive_next  = one_width_reg;
                    out_status_next = STAT_OK;
                    out_byte_next   = '0;
                    out_last_next   = 1'b0;
                    state_next      = ST_TERM;
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_PULSE;
                    out_drive_next  = '0;
                    out_status_next = STAT_OK;
                    out_byte_next   = '0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            zero_width_reg  <= WIDTH_W'(1);
            one_width_reg   <= WIDTH_W'(1);
            threshold_reg   <= WIDTH_W'(1);
            bits_left_reg   <= '0;
            parity_reg      <= 1'b0;
            collect_reg     <= 1'b0;
            width_count_reg <= '0;
            ack_pos_reg     <= '0;
            rx_shift_reg    <= '0;
            header_bad_reg  <= 1'b0;
            skip_echo_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            zero_width_reg  <= zero_width_next;
            one_width_reg   <= one_width_next;
            threshold_reg   <= threshold_next;
            bits_left_reg   <= bits_left_next;
            parity_reg      <= parity_next;
            collect_reg     <= collect_next;
            width_count_reg <= width_count_next;
            ack_pos_reg     <= ack_pos_next;
            rx_shift_reg    <= rx_shift_next;
            header_bad_reg  <= header_bad_next;
            skip_echo_reg   <= skip_echo_next;
            out_valid_reg   <= out_valid_next;
        end
        // payload, no reset needed
        send_shift_reg <= send_shift_next;
        out_kind_reg   <= out_kind_next;
        out_drive_reg  <= out_drive_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = out_kind_reg;
    assign m_drive_width   = out_drive_reg;
    assign m_status_code   = out_status_reg;
    assign m_received_byte = out_byte_reg;
    assign m_last_of_run   = out_last_reg;

    // a run in progress always has a word waiting
    `SWDFL_ASSERT_NOW(a_busy_has_word, aclk, aresetn,
        state_reg != ST_IDLE, out_valid_reg)
    // a send shows its header zero pulse in the next cycle
    `SWDFL_ASSERT_NEXT(a_send_header, aclk, aresetn,
        in_accept && s_opcode == OP_SEND,
        out_valid_reg && out_kind_reg == KIND_PULSE && !out_last_reg
            && out_drive_reg == $past(zero_width_reg))
    // the only pulse word that ends a run is the zero-width terminator
    `SWDFL_ASSERT_NOW(a_last_pulse_is_term, aclk, aresetn,
        out_valid_reg && out_kind_reg == KIND_PULSE && out_last_reg,
        out_drive_reg == '0)
    // collection never counts past the ack slot
    `SWDFL_ASSERT_NOW(a_collect_bound, aclk, aresetn,
        collect_reg, width_count_reg <= ack_pos_reg)
    // receive count stays within header, data and parity slots
    `SWDFL_ASSERT_NOW(a_receive_bound, aclk, aresetn,
        !collect_reg, width_count_reg <= COUNT_W'(DATA_BITS + 1))

endmodule

// ===== verif/tb_single_wire_debug_frame_link.sv =====
// self-checking testbench of single_wire_debug_frame_link: directed table, then random phases
// depends on swdfl_pkg and the rtl of single_wire_debug_frame_link; reads no files
module tb_single_wire_debug_frame_link;
    import swdfl_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 9;
    // a send word keeps the block busy until its terminator leaves, so wait past that
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_WORDS  = 26;
    localparam int RUN_LIMIT    = 6000000;
    localparam int N_DIRECTED   = 29;
    localparam int N_PHASES     = 5;
    // index with no register behind it, writes must be dropped
    localparam reg_index_t REG_SPARE = 2'd3;

    typedef enum logic {MIRROR_RECEIVE, MIRROR_COLLECT} mirror_mode_t;
    typedef enum int {SEQ_SEND, SEQ_RECEIVE, SEQ_BROKEN, SEQ_NOISE} seq_kind_t;

    // one result word as the link emits it
    typedef struct packed {
        kind_t   kind;
        width_t  drive;
        status_t status;
        byte_t   rx_byte;
        logic    last;
    } link_word_t;

    // directed row: input word, plus a hand-typed result where one is obvious
    typedef struct packed {
        logic       op;
        byte_t      value;
        count_t     cnt;
        width_t     width;
        logic       typed;
        link_word_t want;
    } directed_row_t;

    // register settings and idling style of each random phase
    typedef struct packed {
        width_t zero_pw;
        width_t one_pw;
        width_t thresh;
        logic   gaps;
        logic   stalls;
        logic   spare_write;
        logic   draw;
    } phase_cfg_t;

    localparam link_word_t NONE_TYPED = '0;

    // all rows run at the reset settings: zero width 1, one width 1, threshold 1,
    // so a captured width of 0 reads as one and anything else as zero
    localparam directed_row_t DIRECTED [N_DIRECTED] = '{
        // count above eight is sent as eight, all ones value
        '{OP_SEND,    8'hFF, 4'd15, 16'h0000, 1'b0, NONE_TYPED},
        // send while collecting restarts; zero count ignores every value bit
        '{OP_SEND,    8'hA5, 4'd0,  16'hFFFF, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0000, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'hFF, 4'd15, 16'hFFFF, 1'b0, NONE_TYPED},
        // ack width far above threshold: nack
        '{OP_CAPTURE, 8'h00, 4'd0,  16'hFFFF, 1'b1,
          {KIND_STATUS, 16'h0000, STAT_NACK, 8'h00, 1'b1}},
        // header equal to threshold reads as zero: bad header
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0001, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0000, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'hFFFF, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0000, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0000, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h8000, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0000, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'hFFFF, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0000, 1'b0, NONE_TYPED},
        // parity closes the frame: header error, no ack pulse
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0000, 1'b1,
          {KIND_BYTE, 16'h0000, STAT_HDR_ERR, 8'h00, 1'b1}},
        // good frame, data bits 1011_0010
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0000, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0000, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'hFFFF, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0000, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0000, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0001, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'hFFFF, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0000, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'hFFFF, 1'b0, NONE_TYPED},
        // parity is not checked; byte, ack pulse and terminator follow
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h1234, 1'b0, NONE_TYPED},
        // send drops the pending echo skip
        '{OP_SEND,    8'h00, 4'd0,  16'h0000, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0000, 1'b0, NONE_TYPED},
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0000, 1'b0, NONE_TYPED},
        // ack width equal to threshold is still an ack
        '{OP_CAPTURE, 8'h00, 4'd0,  16'h0001, 1'b1,
          {KIND_STATUS, 16'h0000, STAT_OK, 8'h00, 1'b1}}
    };

    // extremes first, then a plain setting with no idling, then a spare-index write, then drawn values
    localparam phase_cfg_t PHASES [N_PHASES] = '{
        '{16'hFFFF, 16'h0001, 16'h8000, 1'b1, 1'b1, 1'b0, 1'b0},
        '{16'h0001, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0},
        '{16'h00C8, 16'h0064, 16'h0096, 1'b0, 1'b0, 1'b0, 1'b0},
        '{16'h1234, 16'h0040, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b1}
    };

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_opcode;
    byte_t      s_frame_value;
    count_t     s_bit_count;
    width_t     s_captured_width;
    logic       m_valid;
    logic       m_ready = 1'b1;
    kind_t      m_result_kind;
    width_t     m_drive_width;
    status_t    m_status_code;
    byte_t      m_received_byte;
    logic       m_last_of_run;
    logic       cfg_valid;
    logic       cfg_ready;
    reg_index_t cfg_index;
    width_t     cfg_data;

    // mirrored link state and register copies
    mirror_mode_t mode_m;
    count_t       wcount_m;
    count_t       ackpos_m;
    byte_t        shift_m;
    logic         hdr_bad_m;
    logic         skip_m;
    width_t       zero_w;
    width_t       one_w;
    width_t       thresh_w;

    // words the link still owes us, oldest first
    link_word_t link_words_q[$];

    int   mismatches;
    int   words_fed;
    int   burst_left;
    bit   sender_gaps;
    bit   receiver_stalls;
    logic [15:0] stall_pat;
    logic [3:0]  stall_tick = 4'd0;

    always #(HALF_PERIOD) aclk = ~aclk;

    single_wire_debug_frame_link u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_frame_value    (s_frame_value),
        .s_bit_count      (s_bit_count),
        .s_captured_width (s_captured_width),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_drive_width    (m_drive_width),
        .m_status_code    (m_status_code),
        .m_received_byte  (m_received_byte),
        .m_last_of_run    (m_last_of_run),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    function automatic void push_word(kind_t k, width_t d, status_t s, byte_t b, logic l);
        link_words_q.push_back({k, d, s, b, l});
    endfunction

    // advance the mirror by one accepted word, queue what the link must emit,
    // return how many words were queued
    function automatic int mirror_link_word(logic op, byte_t value, count_t cnt,
                                            width_t width);
        int   bits;
        int   ones;
        int   i;
        logic b;
        logic is_one;
        ones = 0;
        if (op == OP_SEND) begin
            bits = (cnt > DATA_BITS) ? DATA_BITS : int'(cnt);
            // header is always a zero pulse
            push_word(KIND_PULSE, zero_w, STAT_OK, 8'h00, 1'b0);
            for (i = bits - 1; i >= 0; i--) begin
                b = value[i];
                ones += int'(b);
                push_word(KIND_PULSE, b ? one_w : zero_w, STAT_OK, 8'h00, 1'b0);
            end
            // even parity over the bits actually sent
            push_word(KIND_PULSE, ones[0] ? one_w : zero_w, STAT_OK, 8'h00, 1'b0);
            push_word(KIND_PULSE, 16'h0000, STAT_OK, 8'h00, 1'b1);
            mode_m    = MIRROR_COLLECT;
            wcount_m  = '0;
            ackpos_m  = count_t'(bits + 2);
            shift_m   = '0;
            hdr_bad_m = 1'b0;
            skip_m    = 1'b0;
            return bits + 3;
        end
        is_one = (width < thresh_w);
        if (mode_m == MIRROR_COLLECT) begin
            // echoes of our own pulses first, then the target's ack width
            if (wcount_m >= ackpos_m) begin
                push_word(KIND_STATUS, 16'h0000, (width > thresh_w) ? STAT_NACK : STAT_OK,
                          8'h00, 1'b1);
                mode_m   = MIRROR_RECEIVE;
                wcount_m = '0;
                return 1;
            end
            wcount_m = wcount_m + 1'b1;
            return 0;
        end
        if (skip_m) begin
            // echo of our ack pulse
            skip_m = 1'b0;
            return 0;
        end
        if (wcount_m == 0) begin
            hdr_bad_m = !is_one;
            shift_m   = '0;
            wcount_m  = 4'd1;
            return 0;
        end
        if (wcount_m <= DATA_BITS) begin
            shift_m  = {shift_m[DATA_BITS-2:0], is_one};
            wcount_m = wcount_m + 1'b1;
            return 0;
        end
        // parity width closes the frame
        wcount_m = '0;
        if (hdr_bad_m) begin
            push_word(KIND_BYTE, 16'h0000, STAT_HDR_ERR, 8'h00, 1'b1);
            return 1;
        end
        push_word(KIND_BYTE, 16'h0000, STAT_OK, shift_m, 1'b0);
        push_word(KIND_PULSE, one_w, STAT_OK, 8'h00, 1'b0);
        push_word(KIND_PULSE, 16'h0000, STAT_OK, 8'h00, 1'b1);
        skip_m = 1'b1;
        return 3;
    endfunction

    // present one input word, honoring the burst/gap pattern, and mirror it
    // once the handshake completes
    task automatic feed(logic op, byte_t value, count_t cnt, width_t width, output int pushed);
        int gap;
        if (sender_gaps && burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        s_valid          <= 1'b1;
        s_opcode         <= op;
        s_frame_value    <= value;
        s_bit_count      <= cnt;
        s_captured_width <= width;
        do @(posedge aclk); while (!s_ready);
        pushed = mirror_link_word(op, value, cnt, width);
        words_fed++;
    endtask

    // let every owed word arrive, then give in-flight widths time to settle
    task automatic quiesce();
        s_valid <= 1'b0;
        while (link_words_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, width_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_ZERO_WIDTH: zero_w   = data;
            REG_ONE_WIDTH:  one_w    = data;
            REG_THRESHOLD:  thresh_w = data;
            default: ;
        endcase
    endtask

    // width that reads as the wanted bit under the current threshold (any width if
    // a one is wanted at threshold zero), with the odd extreme thrown in regardless
    function automatic width_t pick_width(logic as_one);
        int t;
        t = int'(thresh_w);
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        if (as_one && t > 0)
            return width_t'($urandom_range(0, t - 1));
        if (!as_one)
            return width_t'($urandom_range(t, 65535));
        return width_t'($urandom);
    endfunction

    // ack widths cluster around the threshold to hit the nack boundary
    function automatic width_t pick_ack_width();
        case ($urandom_range(0, 5))
            0: return thresh_w;
            1: return (thresh_w == 16'hFFFF) ? thresh_w : thresh_w + 1'b1;
            2: return (thresh_w == 16'h0000) ? thresh_w : thresh_w - 1'b1;
            3: return 16'h0000;
            4: return 16'hFFFF;
            default: return width_t'($urandom);
        endcase
    endfunction

    // send word followed by its echoes and the ack; a broken one stops early
    task automatic run_send_frame(bit broken);
        count_t cnt;
        int     bits;
        int     echoes;
        int     pushed;
        cnt = ($urandom_range(0, 7) == 0) ? count_t'($urandom_range(0, 15))
                                         : count_t'($urandom_range(1, DATA_BITS));
        bits   = (cnt > DATA_BITS) ? DATA_BITS : int'(cnt);
        echoes = broken ? $urandom_range(0, bits + 1) : bits + 2;
        feed(OP_SEND, byte_t'($urandom), cnt, width_t'($urandom), pushed);
        repeat (echoes)
            feed(OP_CAPTURE, byte_t'($urandom), count_t'($urandom),
                 pick_width($urandom_range(0, 1) == 1), pushed);
        if (!broken)
            feed(OP_CAPTURE, byte_t'($urandom), count_t'($urandom), pick_ack_width(), pushed);
    endtask

    // header, eight data widths, parity, then the echo of the ack pulse; a broken one stops early
    task automatic run_receive_frame(bit broken);
        int caps;
        int pushed;
        int i;
        caps = broken ? $urandom_range(1, 9) : 10;
        feed(OP_CAPTURE, byte_t'($urandom), count_t'($urandom),
             pick_width($urandom_range(0, 7) != 0), pushed);
        for (i = 1; i < caps; i++)
            feed(OP_CAPTURE, byte_t'($urandom), count_t'($urandom),
                 pick_width($urandom_range(0, 1) == 1), pushed);
        if (!broken)
            feed(OP_CAPTURE, byte_t'($urandom), count_t'($urandom), width_t'($urandom), pushed);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // receiver: compare each accepted word, then pick next cycle's ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (link_words_q.size() == 0) begin
                $error("result word with nothing expected: kind %0h drive %0h",
                       m_result_kind, m_drive_width);
                mismatches++;
            end else begin
                check_field("result_kind",   link_words_q[0].kind,    m_result_kind);
                check_field("drive_width",   link_words_q[0].drive,   m_drive_width);
                check_field("status_code",   link_words_q[0].status,  m_status_code);
                check_field("received_byte", link_words_q[0].rx_byte, m_received_byte);
                check_field("last_of_run",   link_words_q[0].last,    m_last_of_run);
                void'(link_words_q.pop_front());
            end
        end
        if (!receiver_stalls) begin
            m_ready <= 1'b1;
        end else begin
            // 16-bit ready pattern, reloaded every lap, sometimes all ready
            if (stall_tick == 4'd0)
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                       : (16'($urandom) | 16'h0001);
            m_ready <= stall_pat[stall_tick];
            stall_tick = stall_tick + 1'b1;
        end
    end

    initial begin
        int        r;
        int        p;
        int        pushed;
        int        start;
        int        zw;
        int        ow;
        int        roll;
        seq_kind_t seq;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_opcode         = OP_SEND;
        s_frame_value    = '0;
        s_bit_count      = '0;
        s_captured_width = '0;
        cfg_valid        = 1'b0;
        cfg_index        = REG_ZERO_WIDTH;
        cfg_data         = '0;
        // mirror starts from the reset state
        zero_w    = 16'd1;
        one_w     = 16'd1;
        thresh_w  = 16'd1;
        mode_m    = MIRROR_RECEIVE;
        wcount_m  = '0;
        ackpos_m  = '0;
        shift_m   = '0;
        hdr_bad_m = 1'b0;
        skip_m    = 1'b0;
        mismatches      = 0;
        words_fed       = 0;
        burst_left      = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table at reset settings
        for (r = 0; r < N_DIRECTED; r++) begin
            feed(DIRECTED[r].op, DIRECTED[r].value, DIRECTED[r].cnt, DIRECTED[r].width, pushed);
            if (DIRECTED[r].typed) begin
                repeat (pushed) void'(link_words_q.pop_back());
                link_words_q.push_back(DIRECTED[r].want);
            end
        end

        // random phases, registers rewritten only with the link drained
        for (p = 0; p < N_PHASES; p++) begin
            quiesce();
            if (PHASES[p].draw) begin
                zw = $urandom_range(1, 65535);
                ow = $urandom_range(1, 65535);
                write_reg(REG_ZERO_WIDTH, width_t'(zw));
                write_reg(REG_ONE_WIDTH, width_t'(ow));
                write_reg(REG_THRESHOLD, width_t'((zw + ow) / 2));
            end else begin
                write_reg(REG_ZERO_WIDTH, PHASES[p].zero_pw);
                write_reg(REG_ONE_WIDTH, PHASES[p].one_pw);
                write_reg(REG_THRESHOLD, PHASES[p].thresh);
            end
            if (PHASES[p].spare_write)
                write_reg(REG_SPARE, width_t'($urandom));
            cfg_valid <= 1'b0;
            sender_gaps     = PHASES[p].gaps;
            receiver_stalls = PHASES[p].stalls;
            burst_left      = 0;

            start = words_fed;
            while (words_fed - start < PHASE_WORDS) begin
                roll = $urandom_range(0, 9);
                seq  = (roll < 4) ? SEQ_SEND : (roll < 7) ? SEQ_RECEIVE :
                       (roll < 8) ? SEQ_BROKEN : SEQ_NOISE;
                case (seq)
                    SEQ_SEND:    run_send_frame(1'b0);
                    SEQ_RECEIVE: run_receive_frame(1'b0);
                    SEQ_BROKEN: begin
                        if ($urandom_range(0, 1) == 1)
                            run_send_frame(1'b1);
                        else
                            run_receive_frame(1'b1);
                    end
                    default: begin
                        feed(($urandom_range(0, 1) == 1) ? OP_CAPTURE : OP_SEND,
                             byte_t'($urandom), count_t'($urandom_range(0, 15)),
                             width_t'($urandom), pushed);
                    end
                endcase
            end
        end

        quiesce();
        if (mismatches == 0)
            $display("single_wire_debug_frame_link regression: pass");
        else
            $display("single_wire_debug_frame_link regression: fail");
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT);
        $display("single_wire_debug_frame_link regression: fail");
        $finish;
    end

endmodule
